// File: rtl/blbg_pkg.sv
// ----------------------------------------------------------------------------
// blbg_pkg
// Shared types, register indexes, colour codes and helpers for the battery
// LED bar gauge.
// ----------------------------------------------------------------------------
package blbg_pkg;

    localparam int LED_COUNT_DEF = 8;
    localparam int CFG_INDEX_W   = 8;
    localparam int CFG_DATA_W    = 16;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_MV       = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_MV       = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FLASH_PERIOD = 8'd3;

    localparam logic [15:0] MIN_MV_RST       = 16'd0;
    localparam logic [15:0] MAX_MV_RST       = 16'd0;
    localparam logic [7:0]  BRIGHTNESS_RST   = 8'd255;
    localparam logic [15:0] FLASH_PERIOD_RST = 16'd500;

    // colour classes
    localparam logic [1:0] HUE_OFF    = 2'd0;
    localparam logic [1:0] HUE_RED    = 2'd1;
    localparam logic [1:0] HUE_YELLOW = 2'd2;
    localparam logic [1:0] HUE_GREEN  = 2'd3;

    typedef struct packed {
        logic [15:0] voltage_mv;
        logic [31:0] now_ms;
    } in_word_t;

    typedef struct packed {
        logic [7:0] lit_mask;
        logic [1:0] hue_class;
        logic [7:0] level;
    } out_word_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;
        logic setup;
        logic div_step;
        logic write_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_div;
    } status_t;

    // low cnt bits set, only the first eight LEDs are reported
    function automatic logic [7:0] bar_mask(input logic [7:0] cnt);
        logic [7:0] m;
        for (int i = 0; i < 8; i++) begin
            m[i] = (8'(i) < cnt);
        end
        return m;
    endfunction

endpackage

// File: rtl/blbg_ctrl.sv
// ----------------------------------------------------------------------------
// blbg_ctrl
// Sequencer: takes one frame, runs setup, the divide steps when needed, and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module blbg_ctrl import blbg_pkg::*; #(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);

    localparam int QW = $clog2(LED_COUNT + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SETUP = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_WB    = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [QW-1:0] step_reg, step_next;
    logic          out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup = 1'b1;
                step_next = QW'(QW - 1);
                state_next = status.need_div ? S_DIV : S_WB;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                // previous word gone or leaving this edge
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.write_out  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_accept_to_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg == S_SETUP)
        else $error("accepted frame did not enter setup");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && step_reg == '0) |=> state_reg == S_WB)
        else $error("divide did not finish after its last step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.write_out)
        else $error("pending output word overwritten");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("frame taken while another is in flight");

endmodule

// File: rtl/blbg_dp.sv
// ----------------------------------------------------------------------------
// blbg_dp
// Datapath: configuration registers, flash state, range classification,
// restoring divider for the lit count and the output register.
// ----------------------------------------------------------------------------
module blbg_dp import blbg_pkg::*; #(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  in_word_t               in_word,
    input  cmd_t                   cmd,
    output status_t                status,
    output out_word_t              out_word
);

    localparam int QW = $clog2(LED_COUNT + 1);
    localparam int NW = QW + 18;
    localparam logic [7:0] FULL_MASK = bar_mask(8'(LED_COUNT));

    logic [15:0] min_reg, max_reg, period_reg;
    logic [7:0]  bright_reg;
    logic [31:0] last_toggle_reg;
    logic        flash_lit_reg;

    logic [15:0] v_reg;
    logic [31:0] now_reg;

    logic          part_reg;
    logic [7:0]    res_mask_reg;
    logic [1:0]    res_hue_reg;
    logic [7:0]    res_level_reg;
    logic [NW-1:0] rem_reg, dsh_reg;
    logic [QW-1:0] quo_reg;
    out_word_t     out_word_reg;

    logic          range_bad, is_full, is_empty, toggle, lit_after;
    logic [15:0]   d, n;
    logic [31:0]   elapsed;
    logic [18:0]   five_n, d1, d2;
    logic [NW-1:0] num;
    logic          ge;
    logic [QW-1:0] cnt;

    // classification and setup values, from the latched frame
    always_comb
    begin
        range_bad = (max_reg <= min_reg);
        is_full   = (v_reg >= max_reg);
        is_empty  = (v_reg <= min_reg);
        d         = max_reg - min_reg;
        n         = v_reg - min_reg;
        elapsed   = now_reg - last_toggle_reg;
        toggle    = (elapsed >= {16'd0, period_reg});
        lit_after = flash_lit_reg ^ toggle;
        five_n    = (19'(n) << 2) + 19'(n);
        d1        = 19'(d);
        d2        = 19'(d) << 1;
        num       = NW'(n) * NW'(2 * LED_COUNT) + NW'(d);
        ge        = (rem_reg >= dsh_reg);
        if (quo_reg == '0)
        begin
            cnt = QW'(1);
        end
        else if (quo_reg > QW'(LED_COUNT))
        begin
            cnt = QW'(LED_COUNT);
        end
        else
        begin
            cnt = quo_reg;
        end
    end

    assign status.need_div = !range_bad && !is_full && !is_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg         <= MIN_MV_RST;
            max_reg         <= MAX_MV_RST;
            bright_reg      <= BRIGHTNESS_RST;
            period_reg      <= FLASH_PERIOD_RST;
            last_toggle_reg <= '0;
            flash_lit_reg   <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MIN_MV:       min_reg    <= cfg_data;
                    REG_MAX_MV:       max_reg    <= cfg_data;
                    REG_BRIGHTNESS:   bright_reg <= cfg_data[7:0];
                    REG_FLASH_PERIOD: period_reg <= cfg_data;
                    default:          ;
                endcase
            end
            if (cmd.setup && !range_bad && !is_full && is_empty && toggle)
            begin
                last_toggle_reg <= now_reg;
                flash_lit_reg   <= lit_after;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            v_reg   <= in_word.voltage_mv;
            now_reg <= in_word.now_ms;
        end
        if (cmd.setup)
        begin
            part_reg <= status.need_div;
            rem_reg  <= num;
            // divisor 2d aligned to the top quotient bit
            dsh_reg  <= NW'({d, 1'b0}) << (QW - 1);
            quo_reg  <= '0;
            if (range_bad)
            begin
                res_mask_reg  <= '0;
                res_hue_reg   <= HUE_OFF;
                res_level_reg <= '0;
            end
            else if (is_full)
            begin
                res_mask_reg  <= FULL_MASK;
                res_hue_reg   <= HUE_GREEN;
                res_level_reg <= bright_reg;
            end
            else if (is_empty)
            begin
                res_mask_reg  <= lit_after ? FULL_MASK : 8'd0;
                res_hue_reg   <= lit_after ? HUE_RED : HUE_OFF;
                res_level_reg <= lit_after ? bright_reg : 8'd0;
            end
            else
            begin
                res_mask_reg  <= '0;
                res_level_reg <= bright_reg;
                if (five_n <= d1)
                begin
                    res_hue_reg <= HUE_RED;
                end
                else if (five_n <= d2)
                begin
                    res_hue_reg <= HUE_YELLOW;
                end
                else
                begin
                    res_hue_reg <= HUE_GREEN;
                end
            end
        end
        if (cmd.div_step)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quo_reg <= (quo_reg << 1) | QW'(ge);
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.write_out)
        begin
            out_word_reg.lit_mask  <= part_reg ? bar_mask(8'(cnt)) : res_mask_reg;
            out_word_reg.hue_class <= res_hue_reg;
            out_word_reg.level     <= res_level_reg;
        end
    end

    assign out_word = out_word_reg;

endmodule

// File: rtl/battery_led_bar_gauge_core.sv
// ----------------------------------------------------------------------------
// battery_led_bar_gauge_core
// Battery LED bar gauge: voltage frame in, LED mask, colour class and level
// out.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    in_word  (in_word_t)
//   out      source     out_valid / out_stall  out_word (out_word_t)
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One frame at a time: accept, setup, then clog2(LED_COUNT+1) divide steps
// only when the voltage lies strictly between min and max, then write-back.
// The restoring divider retires one quotient bit a cycle; a new frame is
// taken only after write-back.
// Reset: min 0, max 0, brightness 255, flash period 500 ms, flash lit.
// The output register holds a finished word under out_stall while the next
// frame is already taken; cfg is always ready.
// ----------------------------------------------------------------------------
module battery_led_bar_gauge_core import blbg_pkg::*; #(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_word_t               in_word,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_word_t              out_word,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    blbg_ctrl #(
        .LED_COUNT (LED_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    blbg_dp #(
        .LED_COUNT (LED_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .cmd       (cmd),
        .status    (status),
        .out_word  (out_word)
    );

endmodule
